@@ rtl/core/bpv_pkg.sv @@
// Package for the BST preorder validator.
// Holds the status codes, controller states, command and status structs.
// Has no dependencies of its own.
package bpv_pkg;

  localparam int unsigned DEFAULT_STACK_DEPTH = 64;
  localparam int unsigned KEY_W = 32;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_ORDER    = 2'd1,
    STS_DUP      = 2'd2,
    STS_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP_WAIT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic    load_key;
    logic    pop;
    logic    top_load;
    logic    push;
    logic    set_err;
    status_e err_code;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic err_active;
    logic below_bound;
    logic dup_bound;
    logic gt_top;
    logic dup_top;
    logic full;
  } sts_t;

endpackage

@@ rtl/core/bpv_datapath.sv @@
// Datapath of the BST preorder validator: key stack memory, top and bound
// registers, sticky error, duplicate mode register and result register.
// Depends on bpv_pkg.
module bpv_datapath #(
  parameter int unsigned STACK_DEPTH = bpv_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_data_i,
  input  logic [bpv_pkg::KEY_W-1:0]     key_i,
  input  logic                          last_i,
  input  bpv_pkg::cmd_t                 cmd_i,
  output bpv_pkg::sts_t                 sts_o,
  output logic [1:0]                    status_o,
  output logic                          done_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [bpv_pkg::KEY_W-1:0] mem [STACK_DEPTH];
  logic signed [bpv_pkg::KEY_W-1:0] rd_q;
  logic signed [bpv_pkg::KEY_W-1:0] key_q;
  logic signed [bpv_pkg::KEY_W-1:0] top_q;
  logic signed [bpv_pkg::KEY_W-1:0] bound_q;
  logic                             last_q;
  logic                             bound_set_q;
  logic [CW-1:0]                    count_q;
  bpv_pkg::status_e                 err_q;
  logic                             reject_q;
  logic [1:0]                       status_q;
  logic                             done_q;
  logic [CW-1:0]                    rd_idx;
  logic [AW-1:0]                    rd_addr;
  logic [AW-1:0]                    wr_addr;
  logic                             clear;
  logic                             nonempty;

  assign rd_idx   = count_q - CW'(2);
  assign rd_addr  = rd_idx[AW-1:0];
  assign wr_addr  = count_q[AW-1:0];
  assign clear    = cmd_i.emit && last_q;
  assign nonempty = (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_addr] <= key_q;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      key_q  <= key_i;
      last_q <= last_i;
    end
    if (cmd_i.push) begin
      top_q <= key_q;
    end else if (cmd_i.top_load) begin
      top_q <= rd_q;
    end
    if (cmd_i.emit) begin
      status_q <= err_q;
      done_q   <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      bound_q     <= '0;
      bound_set_q <= 1'b0;
      err_q       <= bpv_pkg::STS_OK;
      reject_q    <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        reject_q <= cfg_data_i;
      end
      priority if (clear) begin
        count_q     <= '0;
        bound_q     <= '0;
        bound_set_q <= 1'b0;
        err_q       <= bpv_pkg::STS_OK;
      end else if (cmd_i.pop) begin
        count_q     <= count_q - CW'(1);
        bound_q     <= top_q;
        bound_set_q <= 1'b1;
      end else if (cmd_i.push) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.set_err) begin
        err_q <= cmd_i.err_code;
      end
    end
  end

  always_comb begin
    sts_o.err_active  = (err_q != bpv_pkg::STS_OK);
    sts_o.below_bound = bound_set_q && (key_q < bound_q);
    sts_o.dup_bound   = reject_q && bound_set_q && (key_q == bound_q);
    sts_o.gt_top      = nonempty && (key_q > top_q);
    sts_o.dup_top     = reject_q && nonempty && (key_q == top_q);
    sts_o.full        = (count_q >= CW'(STACK_DEPTH));
  end

  assign status_o = status_q;
  assign done_o   = done_q;

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> count_q < CW'(STACK_DEPTH))
    else $error("Push issued with a full stack.");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> nonempty)
    else $error("Pop issued with an empty stack.");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != bpv_pkg::STS_OK && !clear) |=> $stable(err_q))
    else $error("Error code changed before the sequence ended.");

endmodule

@@ rtl/core/bpv_controller.sv @@
// Controller state machine of the BST preorder validator.
// Sequences key load, stack scan, pops, push and result handoff.
// Depends on bpv_pkg.
module bpv_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  bpv_pkg::sts_t sts_i,
  output bpv_pkg::cmd_t cmd_o
);

  bpv_pkg::state_e state_q;
  bpv_pkg::state_e state_d;
  logic            out_valid_q;
  logic            slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpv_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = bpv_pkg::ST_SCAN;
        end
      end
      bpv_pkg::ST_SCAN: begin
        priority if (sts_i.err_active || sts_i.below_bound || sts_i.dup_bound) begin
          state_d = bpv_pkg::ST_RESP;
        end else if (sts_i.gt_top) begin
          state_d = bpv_pkg::ST_POP_WAIT;
        end else begin
          state_d = bpv_pkg::ST_RESP;
        end
      end
      bpv_pkg::ST_POP_WAIT: begin
        state_d = bpv_pkg::ST_SCAN;
      end
      bpv_pkg::ST_RESP: begin
        if (slot_free) begin
          state_d = bpv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bpv_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.err_code = bpv_pkg::STS_OK;
    in_ready_o     = 1'b0;
    unique case (state_q)
      bpv_pkg::ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_key = in_valid_i;
      end
      bpv_pkg::ST_SCAN: begin
        priority if (sts_i.err_active) begin
          cmd_o.set_err = 1'b0;
        end else if (sts_i.below_bound) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = bpv_pkg::STS_ORDER;
        end else if (sts_i.dup_bound) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = bpv_pkg::STS_DUP;
        end else if (sts_i.gt_top) begin
          cmd_o.pop = 1'b1;
        end else if (sts_i.dup_top) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = bpv_pkg::STS_DUP;
        end else if (sts_i.full) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = bpv_pkg::STS_OVERFLOW;
        end else begin
          cmd_o.push = 1'b1;
        end
      end
      bpv_pkg::ST_POP_WAIT: begin
        cmd_o.top_load = 1'b1;
      end
      bpv_pkg::ST_RESP: begin
        cmd_o.emit = slot_free;
      end
      default: begin
        cmd_o.emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpv_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == bpv_pkg::ST_SCAN)
    else $error("Accepted item did not start a scan.");

  a_wait_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpv_pkg::ST_POP_WAIT) |-> $past(cmd_o.pop))
    else $error("Pop wait entered without a pop.");

  a_resp_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpv_pkg::ST_RESP && out_valid_q && !out_ready_i)
      |=> state_q == bpv_pkg::ST_RESP)
    else $error("Result handoff left while the output slot was busy.");

endmodule

@@ rtl/core/bst_preorder_validator_unit.sv @@
// Top level of the BST preorder validator.
// Instantiates bpv_controller and bpv_datapath; depends on bpv_pkg.
//
// Channel  | Direction | Payload
// s_axis   | in        | tdata[31:0] key (signed), tlast final_key
// m_axis   | out       | tdata[1:0] status, tdata[7:2] zero, tlast sequence_done
// cfg      | in        | data[0] reject_duplicates
//
// An accepted item enters ST_SCAN; each key it pops passes through ST_SCAN
// and ST_POP_WAIT, where the new top is loaded from the registered stack
// memory read. The result is then handed off from ST_RESP, and the unit
// returns to ST_IDLE to take the next item. One item is in work at a time.
// Reset clears the stack count, bound, error and sets reject_duplicates to 1.
// A stalled result is held in the output register; the next item is taken
// once the result of the previous one is in that register.
module bst_preorder_validator_unit #(
  parameter int unsigned STACK_DEPTH = bpv_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] key
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [1:0] status, [7:2] zero
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  bpv_pkg::cmd_t cmd;
  bpv_pkg::sts_t sts;
  logic [1:0]    status;

  assign cfg_ready_o = 1'b1;

  bpv_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bpv_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .key_i      (s_axis_tdata_i),
    .last_i     (s_axis_tlast_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .status_o   (status),
    .done_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'b0, status};

endmodule
